### sv/scaled_alpha_blit_assert.svh
// Assertion macros shared by the blitter RTL.
`ifndef SCALED_ALPHA_BLIT_ASSERT_SVH
`define SCALED_ALPHA_BLIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SAB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SAB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/sab_pkg.sv
// Package with constants and types of the scaled alpha blitter.
package sab_pkg;
    localparam int MAX_WIN_W_DEF   = 256;
    localparam int MAX_WIN_H_DEF   = 256;
    localparam int MAX_SRC_DIM_DEF = 1024;

    localparam logic [2:0] REG_DEST_X = 3'd0;
    localparam logic [2:0] REG_DEST_Y = 3'd1;
    localparam logic [2:0] REG_DEST_W = 3'd2;
    localparam logic [2:0] REG_DEST_H = 3'd3;
    localparam logic [2:0] REG_SRC_W  = 3'd4;
    localparam logic [2:0] REG_SRC_H  = 3'd5;
    localparam logic [2:0] REG_WIN_W  = 3'd6;
    localparam logic [2:0] REG_WIN_H  = 3'd7;

    typedef struct packed {
        logic clr_step;
        logic load;
        logic div_start;
        logic map;
        logic blend;
        logic done;
    } sab_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic visible;
        logic opaque;
        logic transparent;
        logic blend_done;
    } sab_stat_t;
endpackage

### sv/sab_ram.sv
// Generic single-port RAM with registered read.
module sab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### sv/sab_div.sv
// Restoring divider, one quotient bit per cycle.
module sab_div #(
    parameter int NW = 21,
    parameter int DW = 11
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output logic          done
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = num;
            rem_next = '0;
            cnt_next = CW'(NW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= den;
        end
    end

    assign quo = q_reg;
    assign done = done_reg;
endmodule

### sv/sab_datapath.sv
// Datapath: registers, mapping, clipping, blend and frame store.
module sab_datapath
    import sab_pkg::*;
#(
    parameter int MAX_WIN_W = MAX_WIN_W_DEF,
    parameter int MAX_WIN_H = MAX_WIN_H_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  sab_cmd_t    cmd,
    output sab_stat_t   stat,
    input  logic [9:0]  s_src_col,
    input  logic [9:0]  s_src_row,
    input  logic [7:0]  s_texel_r,
    input  logic [7:0]  s_texel_g,
    input  logic [7:0]  s_texel_b,
    input  logic [7:0]  s_texel_a,
    output logic [15:0] m_pixel_index,
    output logic        m_wrote,
    output logic [7:0]  m_out_r,
    output logic [7:0]  m_out_g,
    output logic [7:0]  m_out_b,
    output logic [7:0]  m_out_a
);
    localparam int DEPTH = MAX_WIN_W * MAX_WIN_H;
    localparam int AW = $clog2(DEPTH);
    localparam int NW = 21;
    localparam int WWW = $clog2(MAX_WIN_W + 1);
    localparam int WHW = $clog2(MAX_WIN_H + 1);

    logic [10:0] dx_reg, dy_reg, dw_reg, dh_reg, sw_reg, sh_reg;
    logic [8:0]  ww_reg, wh_reg;
    logic [9:0]  col_reg, row_reg;
    logic [7:0]  tr_reg, tg_reg, tb_reg, ta_reg;
    logic [NW-1:0] qx, qy, qx_reg;
    logic        dvx, dvy, phase_reg;
    logic [AW-1:0] clr_reg, addr_reg;
    logic [15:0] idx_reg;
    logic        vis_reg;
    logic [31:0] rdata, wdata;
    logic        we;
    logic [AW-1:0] addr;
    logic [1:0]  ch_reg;
    logic [31:0] res_reg;
    logic [WWW-1:0] ww;
    logic [WHW-1:0] wh;
    logic [10:0] swd, shd;
    logic [12:0] px, py;
    logic [31:0] idx_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_reg <= '0; dy_reg <= '0; dw_reg <= 11'd1; dh_reg <= 11'd1;
            sw_reg <= 11'd1; sh_reg <= 11'd1; ww_reg <= 9'd256; wh_reg <= 9'd256;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEST_X: dx_reg <= cfg_data;
                REG_DEST_Y: dy_reg <= cfg_data;
                REG_DEST_W: dw_reg <= cfg_data;
                REG_DEST_H: dh_reg <= cfg_data;
                REG_SRC_W:  sw_reg <= cfg_data;
                REG_SRC_H:  sh_reg <= cfg_data;
                REG_WIN_W:  ww_reg <= cfg_data[8:0];
                REG_WIN_H:  wh_reg <= cfg_data[8:0];
                default:    ;
            endcase
        end
    end

    assign ww = ({23'd0, ww_reg} > 32'(MAX_WIN_W)) ? WWW'(MAX_WIN_W) : WWW'(ww_reg);
    assign wh = ({23'd0, wh_reg} > 32'(MAX_WIN_H)) ? WHW'(MAX_WIN_H) : WHW'(wh_reg);
    assign swd = (sw_reg == '0) ? 11'd1 : sw_reg;
    assign shd = (sh_reg == '0) ? 11'd1 : sh_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            col_reg <= s_src_col; row_reg <= s_src_row;
            tr_reg <= s_texel_r; tg_reg <= s_texel_g;
            tb_reg <= s_texel_b; ta_reg <= s_texel_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (cmd.div_start) begin
            phase_reg <= 1'b0;
        end else if (dvx) begin
            phase_reg <= 1'b1;
        end
        if (dvx && !phase_reg) begin
            qx_reg <= qx;
        end
    end

    sab_div #(.NW(NW), .DW(11)) u_div_x (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(NW'(col_reg) * NW'(dw_reg)), .den(swd), .quo(qx), .done(dvx)
    );
    sab_div #(.NW(NW), .DW(11)) u_div_y (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .num(NW'(row_reg) * NW'(dh_reg)), .den(shd), .quo(qy), .done(dvy)
    );
    assign stat.div_done = dvy;

    assign px = {{2{dx_reg[10]}}, dx_reg} + 13'(qx_reg[10:0]);
    assign py = {{2{dy_reg[10]}}, dy_reg} + 13'(qy[10:0]);
    assign idx_full = 32'(py[11:0]) * 32'(ww) + 32'(px[11:0]);

    logic vis;
    assign vis = !px[12] && !py[12] && (qx_reg[NW-1:11] == '0) && (qy[NW-1:11] == '0)
                 && (32'(px) < 32'(ww)) && (32'(py) < 32'(wh));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vis_reg <= 1'b0;
        end else if (cmd.map) begin
            vis_reg <= vis;
        end
        if (cmd.map) begin
            addr_reg <= AW'(idx_full);
            idx_reg <= vis ? idx_full[15:0] : 16'd0;
        end
    end
    assign stat.visible = vis_reg;
    assign stat.opaque = ta_reg == 8'hFF;
    assign stat.transparent = ta_reg == 8'h00;

    logic [7:0] s_ch, d_ch;
    logic [16:0] mix;
    logic [7:0] q255;
    always_comb begin
        case (ch_reg)
            2'd0: begin s_ch = tr_reg; d_ch = rdata[7:0]; end
            2'd1: begin s_ch = tg_reg; d_ch = rdata[15:8]; end
            2'd2: begin s_ch = tb_reg; d_ch = rdata[23:16]; end
            default: begin s_ch = ta_reg; d_ch = rdata[31:24]; end
        endcase
        mix = 17'(s_ch) * 17'(ta_reg) + 17'(d_ch) * 17'(8'hFF - ta_reg);
        q255 = 8'((25'(mix) * 25'd257 + 25'd257) >> 16);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= '0;
        end else if (cmd.blend) begin
            ch_reg <= ch_reg + 2'd1;
        end
        if (cmd.blend) begin
            res_reg <= {q255, res_reg[31:8]};
        end
    end
    assign stat.blend_done = cmd.blend && (ch_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end
    assign stat.clr_last = clr_reg == {AW{1'b1}};

    always_comb begin
        wdata = '0;
        we = 1'b0;
        addr = addr_reg;
        if (cmd.clr_step) begin
            we = 1'b1;
            addr = clr_reg;
        end else if (cmd.done && vis_reg && !stat.transparent) begin
            we = 1'b1;
            wdata = stat.opaque ? {ta_reg, tb_reg, tg_reg, tr_reg} : res_reg;
        end
    end

    sab_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.done) begin
            m_pixel_index <= idx_reg;
            m_wrote <= we;
            m_out_r <= we ? wdata[7:0] : 8'd0;
            m_out_g <= we ? wdata[15:8] : 8'd0;
            m_out_b <= we ? wdata[23:16] : 8'd0;
            m_out_a <= we ? wdata[31:24] : 8'd0;
        end
    end
endmodule

### sv/sab_ctrl.sv
// Controller state machine of the blitter.
module sab_ctrl
    import sab_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output sab_cmd_t  cmd,
    input  sab_stat_t stat
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MAP   = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_BLEND = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;
    localparam logic [2:0] ST_START = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        mv_next = mv_reg;
        cmd = '0;
        s_ready = (state_reg == ST_IDLE);
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP: begin
                cmd.map = 1'b1;
                state_next = ST_RD;
            end
            ST_RD: begin
                state_next = ST_BLEND;
            end
            ST_BLEND: begin
                if (!stat.visible || stat.opaque || stat.transparent) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.blend = 1'b1;
                    if (stat.blend_done) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!mv_reg || m_ready) begin
                    cmd.done = 1'b1;
                    mv_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg <= mv_next;
        end
    end
    assign m_valid = mv_reg;
endmodule

### sv/scaled_alpha_blit.sv
// Top level of the scaled alpha blitter.
// Each input beat passes a start state, the two serial dividers, mapping, a frame store
// read, blending (skipped for a clipped, opaque or transparent texel, else one step for
// each of the four channels) and the write-back. A new beat is accepted only once the last
// one has been written back; a waiting result holds back only the next write-back. After
// reset a clearing pass over all MAX_WIN_W*MAX_WIN_H words zeroes the frame store before the first beat is accepted.
`include "scaled_alpha_blit_assert.svh"
module scaled_alpha_blit
    import sab_pkg::*;
#(
    parameter int MAX_WIN_W = MAX_WIN_W_DEF,
    parameter int MAX_WIN_H = MAX_WIN_H_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [9:0]  s_src_col,
    input  logic [9:0]  s_src_row,
    input  logic [7:0]  s_texel_r,
    input  logic [7:0]  s_texel_g,
    input  logic [7:0]  s_texel_b,
    input  logic [7:0]  s_texel_a,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_index,
    output logic        m_wrote,
    output logic [7:0]  m_out_r,
    output logic [7:0]  m_out_g,
    output logic [7:0]  m_out_b,
    output logic [7:0]  m_out_a
);
    sab_cmd_t  cmd;
    sab_stat_t stat;

    sab_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .stat(stat)
    );

    sab_datapath #(
        .MAX_WIN_W(MAX_WIN_W), .MAX_WIN_H(MAX_WIN_H)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .stat(stat),
        .s_src_col(s_src_col), .s_src_row(s_src_row), .s_texel_r(s_texel_r),
        .s_texel_g(s_texel_g), .s_texel_b(s_texel_b), .s_texel_a(s_texel_a),
        .m_pixel_index(m_pixel_index), .m_wrote(m_wrote), .m_out_r(m_out_r),
        .m_out_g(m_out_g), .m_out_b(m_out_b), .m_out_a(m_out_a)
    );

    `SAB_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SAB_ASSERT_IMP(a_clip_zero, aclk, aresetn, m_valid && !m_wrote && m_out_a != 8'd0, 1'b0)
    `SAB_ASSERT_NXT(a_accept_clears, aclk, aresetn, s_valid && s_ready, !s_ready)
endmodule
